// File: rtl/vtm_pkg.sv
// Shared types and codes for the virtual timer multiplexer.
package vtm_pkg;

   localparam logic [1:0] MODE_TICK   = 2'd0;
   localparam logic [1:0] MODE_START  = 2'd1;
   localparam logic [1:0] MODE_CANCEL = 2'd2;

   localparam logic [1:0] KIND_START_ACK  = 2'd0;
   localparam logic [1:0] KIND_CANCEL_ACK = 2'd1;
   localparam logic [1:0] KIND_FIRED      = 2'd2;

   localparam logic [1:0] STATUS_OK         = 2'd0;
   localparam logic [1:0] STATUS_FULL       = 2'd1;
   localparam logic [1:0] STATUS_NOT_ACTIVE = 2'd2;

   typedef struct packed {
      logic       tok;
      logic       pending;
   } tok_type;

   typedef struct packed {
      logic [1:0] mode;
      logic       repeat_req;
      logic [2:0] cancel_slot;
   } op_type;

   typedef struct packed {
      logic       valid;
      logic [1:0] kind;
      logic [2:0] slot_id;
      logic [1:0] status;
      logic       last;
   } rsp_type;

endpackage

// File: rtl/virtual_timer_multiplexer.sv
// Top level of the virtual timer multiplexer: operation latch, clock of ticks and slot chain.
//
//   channel   ports                                   handshake
//   request   req_mode req_duration req_repeat_req    start & !busy
//             req_cancel_slot
//   result    rsp_kind rsp_slot_id rsp_status          rsp_valid, one cycle, no stall
//             rsp_last
//
// An item keeps busy high while a token walks the row of slot cells, one cell per
// cycle; the next item is taken at the edge after busy falls, so a new item is not
// taken before the token has left the last cell.
// Each slot's result appears in the cycle after the token visits it; a full table or
// an inactive cancel is reported in the cycle after the token visits the last cell.
// Synchronous reset clears the time, busy, the token and every slot's active bit.
module virtual_timer_multiplexer #(
   parameter int NUM_TIMERS = 8,
   parameter int TIME_BITS  = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_mode,
   input  logic [31:0] req_duration,
   input  logic        req_repeat_req,
   input  logic [2:0]  req_cancel_slot,
   output logic        rsp_valid,
   output logic [1:0]  rsp_kind,
   output logic [2:0]  rsp_slot_id,
   output logic [1:0]  rsp_status,
   output logic        rsp_last
);
   import vtm_pkg::*;

   localparam int WIDE = (TIME_BITS > 32) ? TIME_BITS : 32;
   localparam logic [TIME_BITS-1:0] HALF_M1 = {1'b0, {(TIME_BITS-1){1'b1}}};

   logic                 busy_ff, busy_in;
   logic [TIME_BITS-1:0] time_ff, time_in;
   op_type               op_ff;
   logic [TIME_BITS-1:0] dur_ff;
   rsp_type              rsp_ff, rsp_in;
   logic                 accept;
   logic [31:0]          dur_nz;
   logic [WIDE-1:0]      dur_wide, dur_sat;
   tok_type              tok_chain [NUM_TIMERS+1];
   logic                 later [NUM_TIMERS+1];
   rsp_type              cell_rsp [NUM_TIMERS];
   logic [$bits(rsp_type)-1:0] rsp_or;

   assign accept   = start & ~busy_ff;
   assign dur_nz   = (req_duration == 32'd0) ? 32'd1 : req_duration;
   assign dur_wide = WIDE'(dur_nz);
   assign dur_sat  = (dur_wide > WIDE'(HALF_M1)) ? WIDE'(HALF_M1) : dur_wide;

   assign tok_chain[0].tok     = accept;
   assign tok_chain[0].pending = accept & ((req_mode == MODE_START) |
                                           (req_mode == MODE_CANCEL));
   assign later[NUM_TIMERS]    = 1'b0;

   for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_cell
      vtm_cell #(.TIME_BITS(TIME_BITS), .INDEX(i)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .tok_in    (tok_chain[i]),
         .tok_out   (tok_chain[i+1]),
         .op        (op_ff),
         .dur       (dur_ff),
         .now       (time_ff),
         .later_in  (later[i+1]),
         .later_out (later[i]),
         .rsp       (cell_rsp[i])
      );
   end

   always_comb begin
      rsp_or = '0;
      for (int i = 0; i < NUM_TIMERS; i++) begin
         rsp_or = rsp_or | cell_rsp[i];
      end
   end

   always_comb begin
      rsp_in  = rsp_type'(rsp_or);
      busy_in = busy_ff;
      time_in = time_ff;
      if (accept) begin
         busy_in = 1'b1;
         if (req_mode == MODE_TICK) begin
            time_in = time_ff + 1'b1;
         end
      end
      if (tok_chain[NUM_TIMERS].tok) begin
         busy_in = 1'b0;
         if (tok_chain[NUM_TIMERS].pending) begin
            if (op_ff.mode == MODE_START) begin
               rsp_in = '{valid: 1'b1, kind: KIND_START_ACK, slot_id: 3'd0,
                          status: STATUS_FULL, last: 1'b1};
            end else begin
               rsp_in = '{valid: 1'b1, kind: KIND_CANCEL_ACK, slot_id: op_ff.cancel_slot,
                          status: STATUS_NOT_ACTIVE, last: 1'b1};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         time_ff <= '0;
         rsp_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         time_ff <= time_in;
         rsp_ff  <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff  <= '{mode: req_mode, repeat_req: req_repeat_req,
                     cancel_slot: req_cancel_slot};
         dur_ff <= TIME_BITS'(dur_sat);
      end
   end

   assign busy        = busy_ff;
   assign rsp_valid   = rsp_ff.valid;
   assign rsp_kind    = rsp_ff.kind;
   assign rsp_slot_id = rsp_ff.slot_id;
   assign rsp_status  = rsp_ff.status;
   assign rsp_last    = rsp_ff.last;

endmodule

// File: rtl/vtm_cell.sv
// One timer slot of the chain, serving the item while the token sits in it.
module vtm_cell #(
   parameter int TIME_BITS = 32,
   parameter int INDEX     = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  vtm_pkg::tok_type      tok_in,
   output vtm_pkg::tok_type      tok_out,
   input  vtm_pkg::op_type       op,
   input  logic [TIME_BITS-1:0]  dur,
   input  logic [TIME_BITS-1:0]  now,
   input  logic                  later_in,
   output logic                  later_out,
   output vtm_pkg::rsp_type      rsp
);
   import vtm_pkg::*;

   tok_type              tok_ff;
   logic                 valid_ff, valid_in;
   logic                 periodic_ff;
   logic [TIME_BITS-1:0] expiry_ff, expiry_in;
   logic [TIME_BITS-1:0] period_ff;
   logic [TIME_BITS-1:0] diff;
   logic                 active, expired, start_hit, cancel_hit, fire_hit;

   assign active     = tok_ff.tok;
   assign diff       = now - expiry_ff;
   assign expired    = valid_ff & ~diff[TIME_BITS-1];
   assign start_hit  = active & tok_ff.pending & (op.mode == MODE_START) & ~valid_ff;
   assign cancel_hit = active & (op.mode == MODE_CANCEL) & valid_ff &
                       ({29'd0, op.cancel_slot} == 32'(INDEX));
   assign fire_hit   = active & (op.mode == MODE_TICK) & expired;
   assign later_out  = later_in | expired;

   always_comb begin
      valid_in  = valid_ff;
      expiry_in = expiry_ff;
      if (start_hit) begin
         valid_in  = 1'b1;
         expiry_in = now + dur;
      end else if (cancel_hit) begin
         valid_in = 1'b0;
      end else if (fire_hit) begin
         if (periodic_ff) begin
            expiry_in = expiry_ff + period_ff;
         end else begin
            valid_in = 1'b0;
         end
      end
   end

   always_comb begin
      tok_out.tok     = active;
      tok_out.pending = tok_ff.pending & ~start_hit & ~cancel_hit;
      rsp = '0;
      if (start_hit) begin
         rsp = '{valid: 1'b1, kind: KIND_START_ACK, slot_id: 3'(INDEX),
                 status: STATUS_OK, last: 1'b1};
      end else if (cancel_hit) begin
         rsp = '{valid: 1'b1, kind: KIND_CANCEL_ACK, slot_id: 3'(INDEX),
                 status: STATUS_OK, last: 1'b1};
      end else if (fire_hit) begin
         rsp = '{valid: 1'b1, kind: KIND_FIRED, slot_id: 3'(INDEX),
                 status: STATUS_OK, last: ~later_in};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         tok_ff   <= tok_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      expiry_ff <= expiry_in;
      if (start_hit) begin
         period_ff   <= dur;
         periodic_ff <= op.repeat_req;
      end
   end

endmodule

// File: rtl/vtm_checker.sv
// Port-level checks for the virtual timer multiplexer and their binding.
module vtm_checker (
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic       rsp_valid,
   input logic [1:0] rsp_kind,
   input logic [1:0] rsp_status,
   input logic       rsp_last
);
   import vtm_pkg::*;

   a_accept_busy : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy did not rise after an item was taken");

   a_accept_quiet : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> !rsp_valid)
      else $error("result shown in the cycle after an item was taken");

   a_rsp_in_work : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result without an item at work");

   a_ack_last : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind != KIND_FIRED) |-> rsp_last)
      else $error("acknowledge result not marked last");

   a_fired_ok : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == KIND_FIRED) |-> (rsp_status == STATUS_OK))
      else $error("fired result with a status other than ok");

endmodule

bind virtual_timer_multiplexer vtm_checker u_vtm_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_valid  (rsp_valid),
   .rsp_kind   (rsp_kind),
   .rsp_status (rsp_status),
   .rsp_last   (rsp_last)
);

// File: dv/virtual_timer_multiplexer_tb.sv
// Self-checking testbench for the virtual timer multiplexer: directed table, then random items.
module virtual_timer_multiplexer_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import vtm_pkg::*;

   localparam int NUM_TIMERS = 8;
   localparam int STALL_LIMIT = 2000;
   localparam int RANDOM_ITEMS = 97;
   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam logic [31:0] MAX_DURATION = 32'h7FFF_FFFF;

   typedef struct packed {
      logic [1:0]  kind;
      logic [2:0]  slot_id;
      logic [1:0]  status;
      logic        last;
   } timer_result_type;

   typedef struct packed {
      logic [1:0]  mode;
      logic [31:0] duration;
      logic        repeat_req;
      logic [2:0]  cancel_slot;
      logic        typed;
      logic [1:0]  kind;
      logic [2:0]  slot_id;
      logic [1:0]  status;
   } timer_op_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_mode = MODE_TICK;
   logic [31:0] req_duration = '0;
   logic        req_repeat_req = 1'b0;
   logic [2:0]  req_cancel_slot = '0;
   logic        rsp_valid;
   logic [1:0]  rsp_kind;
   logic [2:0]  rsp_slot_id;
   logic [1:0]  rsp_status;
   logic        rsp_last;

   logic [31:0] model_now = '0;
   logic [31:0] model_expiry [NUM_TIMERS];
   logic [31:0] model_period [NUM_TIMERS];
   logic        model_periodic [NUM_TIMERS];
   logic        model_active [NUM_TIMERS] = '{default: 1'b0};

   timer_result_type expected_results [$];
   timer_op_type     ops_in_flight [$];
   int               error_count = 0;
   int               stall_cycles = 0;

   // Rows with typed = 1 carry their single acknowledge; the others use the predictor.
   timer_op_type directed_ops [23] = '{
      '{MODE_CANCEL, 32'd0, 1'b0, 3'd0, 1'b1, KIND_CANCEL_ACK, 3'd0, STATUS_NOT_ACTIVE},
      '{MODE_CANCEL, 32'd0, 1'b0, 3'd7, 1'b1, KIND_CANCEL_ACK, 3'd7, STATUS_NOT_ACTIVE},
      '{MODE_TICK, 32'd0, 1'b0, 3'd0, 1'b0, KIND_START_ACK, 3'd0, STATUS_OK},
      '{MODE_START, 32'd0, 1'b0, 3'd0, 1'b1, KIND_START_ACK, 3'd0, STATUS_OK},
      '{MODE_TICK, 32'd0, 1'b0, 3'd0, 1'b0, KIND_START_ACK, 3'd0, STATUS_OK},
      '{MODE_START, 32'd1, 1'b1, 3'd0, 1'b1, KIND_START_ACK, 3'd0, STATUS_OK},
      '{MODE_START, 32'hFFFF_FFFF, 1'b0, 3'd0, 1'b1, KIND_START_ACK, 3'd1, STATUS_OK},
      '{MODE_START, 32'h8000_0000, 1'b1, 3'd0, 1'b1, KIND_START_ACK, 3'd2, STATUS_OK},
      '{MODE_START, 32'd3, 1'b1, 3'd0, 1'b1, KIND_START_ACK, 3'd3, STATUS_OK},
      '{MODE_START, 32'h7FFF_FFFF, 1'b0, 3'd0, 1'b1, KIND_START_ACK, 3'd4, STATUS_OK},
      '{MODE_START, 32'd5, 1'b0, 3'd0, 1'b1, KIND_START_ACK, 3'd5, STATUS_OK},
      '{MODE_START, 32'd2, 1'b1, 3'd0, 1'b1, KIND_START_ACK, 3'd6, STATUS_OK},
      '{MODE_START, 32'd1, 1'b0, 3'd0, 1'b1, KIND_START_ACK, 3'd7, STATUS_OK},
      '{MODE_START, 32'd10, 1'b1, 3'd0, 1'b1, KIND_START_ACK, 3'd0, STATUS_FULL},
      '{MODE_TICK, 32'd0, 1'b0, 3'd0, 1'b0, KIND_START_ACK, 3'd0, STATUS_OK},
      '{MODE_TICK, 32'd0, 1'b0, 3'd0, 1'b0, KIND_START_ACK, 3'd0, STATUS_OK},
      '{MODE_TICK, 32'd0, 1'b0, 3'd0, 1'b0, KIND_START_ACK, 3'd0, STATUS_OK},
      '{MODE_CANCEL, 32'd0, 1'b0, 3'd3, 1'b1, KIND_CANCEL_ACK, 3'd3, STATUS_OK},
      '{MODE_CANCEL, 32'd0, 1'b0, 3'd3, 1'b1, KIND_CANCEL_ACK, 3'd3, STATUS_NOT_ACTIVE},
      '{MODE_UNUSED, 32'hFFFF_FFFF, 1'b1, 3'd7, 1'b0, KIND_START_ACK, 3'd0, STATUS_OK},
      '{MODE_START, 32'h5555_5555, 1'b1, 3'd5, 1'b0, KIND_START_ACK, 3'd0, STATUS_OK},
      '{MODE_CANCEL, 32'd0, 1'b0, 3'd2, 1'b1, KIND_CANCEL_ACK, 3'd2, STATUS_OK},
      '{MODE_CANCEL, 32'd0, 1'b0, 3'd1, 1'b1, KIND_CANCEL_ACK, 3'd1, STATUS_OK}
   };

   virtual_timer_multiplexer #(
      .NUM_TIMERS(NUM_TIMERS),
      .TIME_BITS(32)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_mode(req_mode),
      .req_duration(req_duration),
      .req_repeat_req(req_repeat_req),
      .req_cancel_slot(req_cancel_slot),
      .rsp_valid(rsp_valid),
      .rsp_kind(rsp_kind),
      .rsp_slot_id(rsp_slot_id),
      .rsp_status(rsp_status),
      .rsp_last(rsp_last)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // Applies one operation to the timer table and queues the results it causes.
   function automatic void predict_timer_results(input timer_op_type op);
      logic [31:0] lapse;
      logic [31:0] span;
      int          first_new;
      bit          placed;
      first_new = expected_results.size();
      placed = 1'b0;
      case (op.mode)
         MODE_TICK: begin
            model_now = model_now + 32'd1;
            for (int i = 0; i < NUM_TIMERS; i++) begin
               lapse = model_now - model_expiry[i];
               if (model_active[i] && !lapse[31]) begin
                  expected_results.push_back('{KIND_FIRED, 3'(i), STATUS_OK, 1'b0});
                  if (model_periodic[i]) begin
                     model_expiry[i] = model_expiry[i] + model_period[i];
                  end else begin
                     model_active[i] = 1'b0;
                  end
               end
            end
            if (expected_results.size() > first_new) begin
               expected_results[expected_results.size() - 1].last = 1'b1;
            end
         end
         MODE_START: begin
            span = (op.duration == 32'd0) ? 32'd1 : op.duration;
            if (span > MAX_DURATION) begin
               span = MAX_DURATION;
            end
            for (int i = 0; i < NUM_TIMERS; i++) begin
               if (!placed && !model_active[i]) begin
                  placed = 1'b1;
                  model_active[i] = 1'b1;
                  model_periodic[i] = op.repeat_req;
                  model_period[i] = span;
                  model_expiry[i] = model_now + span;
                  expected_results.push_back('{KIND_START_ACK, 3'(i), STATUS_OK, 1'b1});
               end
            end
            if (!placed) begin
               expected_results.push_back('{KIND_START_ACK, 3'd0, STATUS_FULL, 1'b1});
            end
         end
         MODE_CANCEL: begin
            if (model_active[op.cancel_slot]) begin
               model_active[op.cancel_slot] = 1'b0;
               expected_results.push_back('{KIND_CANCEL_ACK, op.cancel_slot, STATUS_OK,
                                            1'b1});
            end else begin
               expected_results.push_back('{KIND_CANCEL_ACK, op.cancel_slot,
                                            STATUS_NOT_ACTIVE, 1'b1});
            end
         end
         default: begin
         end
      endcase
      if (op.typed && expected_results.size() > first_new) begin
         expected_results[expected_results.size() - 1] =
            '{op.kind, op.slot_id, op.status, 1'b1};
      end
   endfunction

   function automatic timer_op_type random_timer_op();
      timer_op_type op;
      int           roll;
      roll = $urandom_range(0, 99);
      op = '0;
      op.mode = (roll < 45) ? MODE_TICK : (roll < 75) ? MODE_START :
                (roll < 95) ? MODE_CANCEL : MODE_UNUSED;
      roll = $urandom_range(0, 9);
      op.duration = (roll == 0) ? 32'd0 : (roll == 1) ? 32'($urandom()) :
                    32'($urandom_range(1, 12));
      op.repeat_req = 1'($urandom_range(0, 1));
      op.cancel_slot = 3'($urandom_range(0, 7));
      return op;
   endfunction

   // Called at a rising edge; returns at the edge where the item is accepted.
   task automatic send_item(input timer_op_type op, input int idle_pct);
      int gap;
      gap = ($urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 12) : 0;
      repeat (gap) begin
         start <= 1'b0;
         @(posedge clock);
      end
      ops_in_flight.push_back(op);
      start <= 1'b1;
      req_mode <= op.mode;
      req_duration <= op.duration;
      req_repeat_req <= op.repeat_req;
      req_cancel_slot <= op.cancel_slot;
      do begin
         @(posedge clock);
      end while (busy);
   endtask

   always @(posedge clock) begin
      timer_result_type want;
      if (!reset) begin
         if (rsp_valid) begin
            if (expected_results.size() == 0) begin
               report_mismatch("result with nothing expected, slot_id",
                               32'(rsp_slot_id), 32'd0);
            end else begin
               want = expected_results.pop_front();
               if (rsp_kind !== want.kind) begin
                  report_mismatch("kind", 32'(rsp_kind), 32'(want.kind));
               end
               if (rsp_slot_id !== want.slot_id) begin
                  report_mismatch("slot_id", 32'(rsp_slot_id), 32'(want.slot_id));
               end
               if (rsp_status !== want.status) begin
                  report_mismatch("status", 32'(rsp_status), 32'(want.status));
               end
               if (rsp_last !== want.last) begin
                  report_mismatch("last", 32'(rsp_last), 32'(want.last));
               end
            end
         end
         if (start && !busy) begin
            predict_timer_results(ops_in_flight.pop_front());
         end
      end
   end

   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      foreach (directed_ops[k]) begin
         send_item(directed_ops[k], 0);
      end
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         send_item(random_timer_op(), (n < 32) ? 9 : (n < 64) ? 45 : 0);
      end
      start <= 1'b0;
      do begin
         @(posedge clock);
      end while (expected_results.size() != 0);
      repeat (2 * NUM_TIMERS + 4) @(posedge clock);
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// File: files.f
rtl/vtm_pkg.sv
rtl/vtm_cell.sv
rtl/virtual_timer_multiplexer.sv
rtl/vtm_checker.sv
dv/virtual_timer_multiplexer_tb.sv
